/* hdl/block_rms_peak_level_meter_unit_defines.svh */
// Assertion macros for the block RMS and peak level meter.
// Used by the checker; needs nothing else.
`ifndef BLOCK_RMS_PEAK_LEVEL_METER_UNIT_DEFINES_SVH
`define BLOCK_RMS_PEAK_LEVEL_METER_UNIT_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define RPLM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rplm check failed");

// antecedent holds -> consequent in the next cycle
`define RPLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rplm check failed");

`endif

/* hdl/rplm_pkg.sv */
// Shared types and constants of the block RMS and peak level meter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rplm_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int PEAK_W      = 23;
   localparam int RMS_W       = 24;
   localparam int COUNT_OUT_W = 13;
   localparam int SQUARE_W    = 47;
   localparam int SUM_W       = 58;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int DIV_STEPS   = SUM_W;
   localparam int ROOT_STEPS  = ROOT_W;
   localparam int ITER_W      = 6;
   localparam int RSP_DATA_W  = 64;

   localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
   localparam logic [RMS_W-1:0] RMS_ONE   = 24'h800000;

   typedef struct packed {
      logic capture;
      logic square;
      logic accum;
      logic div_init;
      logic div_step;
      logic root_init;
      logic root_step;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic block_end;
      logic div_last;
      logic root_last;
   } sts_type;

endpackage

`default_nettype wire

/* hdl/rplm_controller.sv */
// Sequencer of the level meter: per-sample steps, divide, root, result load.
// Depends on rplm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rplm_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output rplm_pkg::cmd_type      cmd,
   input  wire rplm_pkg::sts_type sts
);
   import rplm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ACCUM  = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_ROOT   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (sts.block_end) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.root_init = 1'b1;
               state_in      = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/rplm_datapath.sv */
// Datapath of the level meter: square, saturating sum, peak, count,
// restoring divider, digit-by-digit square root and result register.
// Depends on rplm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rplm_datapath #(
   parameter int MAX_BLOCK = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [rplm_pkg::SAMPLE_W-1:0]      sample,
   input  wire logic                               last_in_block,
   input  wire rplm_pkg::cmd_type                  cmd,
   output rplm_pkg::sts_type                       sts,
   output logic [rplm_pkg::RMS_W-1:0]              rms_level,
   output logic [rplm_pkg::PEAK_W-1:0]             peak_level,
   output logic [rplm_pkg::COUNT_OUT_W-1:0]        sample_count
);
   import rplm_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [SQUARE_W-1:0] sq_ff, sq_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PEAK_W-1:0]   peak_ff, peak_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                last_ff, last_in;

   logic [CNT_W-1:0]    divisor_ff, divisor_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;

   logic [PEAK_W-1:0]   peak_res_ff, peak_res_in;
   logic [CNT_W-1:0]    count_res_ff, count_res_in;
   logic [RMS_W-1:0]    rms_out_ff, rms_out_in;
   logic [PEAK_W-1:0]   peak_out_ff, peak_out_in;
   logic [COUNT_OUT_W-1:0] count_out_ff, count_out_in;

   logic [SUM_W:0]      sum_ext;
   logic [SUM_W-1:0]    sum_sat;
   logic [CNT_W:0]      div_trial;
   logic [CNT_W:0]      div_diff;
   logic                div_ge;
   logic [SREM_W+1:0]   rt_trial;
   logic [SREM_W+1:0]   rt_sub;
   logic [SREM_W+1:0]   rt_diff;
   logic                rt_ge;
   logic [RMS_W-1:0]    rms_clamped;

   always_comb begin
      sum_ext   = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
      sum_sat   = sum_ext[SUM_W] ? SUM_LIMIT : sum_ext[SUM_W-1:0];

      div_trial = {rem_ff, quot_ff[SUM_W-1]};
      div_diff  = div_trial - {1'b0, divisor_ff};
      div_ge    = (div_trial >= {1'b0, divisor_ff});

      rt_trial  = {srem_ff, quot_ff[SUM_W-1:SUM_W-2]};
      rt_sub    = {2'b00, root_ff, 2'b01};
      rt_diff   = rt_trial - rt_sub;
      rt_ge     = (rt_trial >= rt_sub);

      rms_clamped = (root_ff > ROOT_W'(RMS_ONE)) ? RMS_ONE : root_ff[RMS_W-1:0];

      sts.block_end = last_ff || (count_ff == CNT_W'(MAX_BLOCK));
      sts.div_last  = (iter_ff == ITER_W'(DIV_STEPS - 1));
      sts.root_last = (iter_ff == ITER_W'(ROOT_STEPS - 1));
   end

   always_comb begin
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      peak_res_in  = peak_res_ff;
      count_res_in = count_res_ff;
      rms_out_in   = rms_out_ff;
      peak_out_in  = peak_out_ff;
      count_out_in = count_out_ff;

      if (cmd.capture) begin
         mag_in   = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
         last_in  = last_in_block;
         count_in = count_ff + 1'b1;
         if (!sample[SAMPLE_W-1] && (sample[PEAK_W-1:0] > peak_ff)) begin
            peak_in = sample[PEAK_W-1:0];
         end
      end

      if (cmd.square) begin
         sq_in = SQUARE_W'(mag_ff) * SQUARE_W'(mag_ff);
      end

      if (cmd.accum) begin
         sum_in = sum_sat;
      end

      if (cmd.div_init) begin
         quot_in      = sum_sat;
         rem_in       = '0;
         divisor_in   = count_ff;
         iter_in      = '0;
         peak_res_in  = peak_ff;
         count_res_in = count_ff;
         sum_in       = '0;
         peak_in      = '0;
         count_in     = '0;
         last_in      = 1'b0;
      end

      if (cmd.div_step) begin
         quot_in = {quot_ff[SUM_W-2:0], div_ge};
         rem_in  = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
         iter_in = iter_ff + 1'b1;
      end

      if (cmd.root_step) begin
         quot_in = {quot_ff[SUM_W-3:0], 2'b00};
         srem_in = rt_ge ? rt_diff[SREM_W-1:0] : rt_trial[SREM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], rt_ge};
         iter_in = iter_ff + 1'b1;
      end

      // root start overrides the final divide step's counter update
      if (cmd.root_init) begin
         srem_in = '0;
         root_in = '0;
         iter_in = '0;
      end

      if (cmd.load_result) begin
         rms_out_in   = rms_clamped;
         peak_out_in  = peak_res_ff;
         count_out_in = COUNT_OUT_W'(count_res_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
         last_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         sum_ff   <= sum_in;
         peak_ff  <= peak_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      peak_res_ff  <= peak_res_in;
      count_res_ff <= count_res_in;
      rms_out_ff   <= rms_out_in;
      peak_out_ff  <= peak_out_in;
      count_out_ff <= count_out_in;
   end

   assign rms_level    = rms_out_ff;
   assign peak_level   = peak_out_ff;
   assign sample_count = count_out_ff;

endmodule

`default_nettype wire

/* hdl/block_rms_peak_level_meter_unit.sv */
// Top level of the block RMS and peak level meter.
// Depends on rplm_pkg, rplm_controller and rplm_datapath.
//
//   channel  dir  payload
//   req_     in   tdata[23:0] sample, tlast last_in_block
//   rsp_     out  tdata[23:0] rms_level, [46:24] peak_level, [59:47] sample_count
//
// Each sample goes through capture, 24x24 square and saturating accumulate.
// A block end adds a restoring divide (one quotient bit per cycle), a square
// root (one root bit per cycle) and a load of the result register.
// Reset clears the accumulators and the state; no result is pending after it.
// A result waiting on rsp_tready holds; samples keep being taken meanwhile,
// and only the next block end waits for the result register to free up.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_peak_level_meter_unit #(
   parameter int MAX_BLOCK = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [rplm_pkg::SAMPLE_W-1:0]        req_tdata,  // [23:0] sample
   input  wire logic                                 req_tlast,  // last_in_block
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [23:0] rms_level, [46:24] peak_level, [59:47] sample_count, [63:60] zero
   output logic [rplm_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import rplm_pkg::*;

   cmd_type                cmd;
   sts_type                sts;
   logic [RMS_W-1:0]       rms_level;
   logic [PEAK_W-1:0]      peak_level;
   logic [COUNT_OUT_W-1:0] sample_count;

   rplm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rplm_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .sample        (req_tdata),
      .last_in_block (req_tlast),
      .cmd           (cmd),
      .sts           (sts),
      .rms_level     (rms_level),
      .peak_level    (peak_level),
      .sample_count  (sample_count)
   );

   assign rsp_tdata = {(RSP_DATA_W - RMS_W - PEAK_W - COUNT_OUT_W)'(0),
                       sample_count, peak_level, rms_level};

endmodule

`default_nettype wire

/* hdl/rplm_checker.sv */
// Port-level checks of the level meter, bound to the top level.
// Depends on block_rms_peak_level_meter_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "block_rms_peak_level_meter_unit_defines.svh"

module rplm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   `RPLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `RPLM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `RPLM_ASSERT_SAME(a_rms_clamp, clock, reset, rsp_tvalid, !(rsp_tdata[23] && (rsp_tdata[22:0] != 23'd0)))
   `RPLM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind block_rms_peak_level_meter_unit rplm_checker u_rplm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
